// ----- rtl/hcw_pkg.sv -----
// ----------------------------------------------------------------------------
// hcw_pkg
// Shared types, constants and helper functions for the hex command line
// byte writer.
// ----------------------------------------------------------------------------
`default_nettype none

package hcw_pkg;

   localparam int STORE_BYTES = 1024;
   localparam int LINE_LIMIT  = 20;
   localparam int LINE_CAP    = LINE_LIMIT - 1;
   localparam int STORE_AW    = $clog2(STORE_BYTES);
   localparam int COUNT_W     = $clog2(LINE_LIMIT);
   localparam int LINE_IDX_W  = $clog2(LINE_CAP);

   localparam logic [7:0] CH_DEL = 8'h7F;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_FILL = 8'hFF;

   typedef enum logic [1:0] {
      STATUS_WRITTEN = 2'd0,
      STATUS_SAME    = 2'd1,
      STATUS_BAD     = 2'd2,
      STATUS_RANGE   = 2'd3
   } status_type;

   typedef enum logic {
      KIND_ECHO    = 1'b0,
      KIND_OUTCOME = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ECHO,
      S_PARSE,
      S_DECIDE
   } state_type;

   typedef enum logic [1:0] {
      ACT_ERASE,
      ACT_STORE,
      ACT_END
   } action_type;

   typedef enum logic [1:0] {
      PH_ADDR,
      PH_GAP,
      PH_VALUE
   } phase_type;

   // Edit and parse requests from the sequencer to the line unit.
   typedef struct packed {
      logic       push;
      logic       pop;
      logic       start;
      logic [7:0] ch;
   } line_cmd_type;

   // Line unit status and the parsed command.
   typedef struct packed {
      logic        empty;
      logic        full;
      logic        done;
      logic        bad;
      logic [15:0] addr;
      logic [7:0]  val;
   } line_stat_type;

   // Access to the byte store.
   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } store_req_type;

   // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic logic is_line_char(input logic [7:0] c);
      logic [4:0] h;
      h = hex_decode(c);
      return h[4] || (c == CH_SP);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/hcw_ifs.sv -----
// ----------------------------------------------------------------------------
// hcw channel interfaces
// Valid/ready channels for received characters and for results.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_char;

   modport source (output valid, output rx_char, input ready);
   modport sink   (input valid, input rx_char, output ready);
endinterface

interface hcw_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  tx_char;
   logic [1:0]  status;
   logic [15:0] address;
   logic [7:0]  data_value;
   logic [7:0]  old_value;
   logic        last;

   modport source (output valid, output kind, output tx_char, output status,
                   output address, output data_value, output old_value,
                   output last, input ready);
   modport sink   (input valid, input kind, input tx_char, input status,
                   input address, input data_value, input old_value,
                   input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/hcw_byte_store.sv -----
// ----------------------------------------------------------------------------
// hcw_byte_store
// Byte store with registered read and a fill sweep to 0xFF after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hcw_byte_store (
   input  wire                     clock,
   input  wire                     reset,
   input  hcw_pkg::store_req_type  req,
   output logic [7:0]              rd_data,
   output logic                    busy
);

   logic [7:0]                   mem [hcw_pkg::STORE_BYTES];
   logic [hcw_pkg::STORE_AW-1:0] clr_idx_ff;
   logic [hcw_pkg::STORE_AW-1:0] clr_idx_in;
   logic                         clearing_ff;
   logic                         clearing_in;
   logic                         wr_en;
   logic [hcw_pkg::STORE_AW-1:0] wr_addr;
   logic [7:0]                   wr_data;

   always_comb begin
      clr_idx_in  = clr_idx_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == hcw_pkg::STORE_AW'(hcw_pkg::STORE_BYTES - 1)) begin
            clearing_in = 1'b0;
         end
      end
      wr_en   = clearing_ff ? 1'b1 : req.wr_en;
      wr_addr = clearing_ff ? clr_idx_ff : req.addr;
      wr_data = clearing_ff ? hcw_pkg::CH_FILL : req.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff  <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_idx_ff  <= clr_idx_in;
         clearing_ff <= clearing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data <= mem[req.addr];
      end
   end

   assign busy = clearing_ff;

endmodule

`default_nettype wire

// ----- rtl/hcw_line_unit.sv -----
// ----------------------------------------------------------------------------
// hcw_line_unit
// Line buffer and a parser that walks it at most one character per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hcw_line_unit (
   input  wire                     clock,
   input  wire                     reset,
   input  hcw_pkg::line_cmd_type   cmd,
   output hcw_pkg::line_stat_type  stat
);

   logic [7:0]                  line_ff [hcw_pkg::LINE_CAP];
   logic [hcw_pkg::COUNT_W-1:0] count_ff;
   logic [hcw_pkg::COUNT_W-1:0] count_in;
   logic [hcw_pkg::COUNT_W-1:0] idx_ff;
   logic [hcw_pkg::COUNT_W-1:0] idx_in;
   logic [2:0]                  digits_ff;
   logic [2:0]                  digits_in;
   logic [15:0]                 addr_ff;
   logic [15:0]                 addr_in;
   logic [7:0]                  val_ff;
   logic [7:0]                  val_in;
   logic                        busy_ff;
   logic                        busy_in;
   logic                        done_ff;
   logic                        done_in;
   logic                        bad_ff;
   logic                        bad_in;
   hcw_pkg::phase_type          phase_ff;
   hcw_pkg::phase_type          phase_in;
   logic [7:0]                  cur_char;
   logic [4:0]                  cur_hex;
   logic                        at_end;

   assign at_end   = (idx_ff >= count_ff);
   assign cur_char = line_ff[idx_ff[hcw_pkg::LINE_IDX_W-1:0]];
   assign cur_hex  = hcw_pkg::hex_decode(cur_char);

   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      digits_in = digits_ff;
      addr_in   = addr_ff;
      val_in    = val_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      bad_in    = bad_ff;
      phase_in  = phase_ff;

      if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end

      if (cmd.start) begin
         busy_in   = 1'b1;
         phase_in  = hcw_pkg::PH_ADDR;
         idx_in    = '0;
         digits_in = '0;
         addr_in   = '0;
         val_in    = '0;
         bad_in    = 1'b0;
      end else if (busy_ff) begin
         case (phase_ff)
            hcw_pkg::PH_ADDR: begin
               if (!at_end && cur_char != hcw_pkg::CH_SP) begin
                  if (digits_ff == 3'd4 || !cur_hex[4]) begin
                     busy_in = 1'b0;
                     done_in = 1'b1;
                     bad_in  = 1'b1;
                  end else begin
                     addr_in   = {addr_ff[11:0], cur_hex[3:0]};
                     digits_in = digits_ff + 3'd1;
                     idx_in    = idx_ff + 1'b1;
                  end
               end else if (digits_ff == 3'd0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  bad_in  = 1'b1;
               end else begin
                  phase_in = hcw_pkg::PH_GAP;
               end
            end
            hcw_pkg::PH_GAP: begin
               if (!at_end && cur_char == hcw_pkg::CH_SP) begin
                  idx_in = idx_ff + 1'b1;
               end else begin
                  phase_in  = hcw_pkg::PH_VALUE;
                  digits_in = '0;
               end
            end
            hcw_pkg::PH_VALUE: begin
               if (!at_end) begin
                  if (digits_ff == 3'd2 || !cur_hex[4]) begin
                     busy_in = 1'b0;
                     done_in = 1'b1;
                     bad_in  = 1'b1;
                  end else begin
                     val_in    = {val_ff[3:0], cur_hex[3:0]};
                     digits_in = digits_ff + 3'd1;
                     idx_in    = idx_ff + 1'b1;
                  end
               end else begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  bad_in  = (digits_ff == 3'd0);
               end
            end
            default: begin
               busy_in = 1'b0;
               done_in = 1'b1;
               bad_in  = 1'b1;
            end
         endcase
         // The line is consumed once the walk is over.
         if (done_in) begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= hcw_pkg::PH_ADDR;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      digits_ff <= digits_in;
      addr_ff   <= addr_in;
      val_ff    <= val_in;
      bad_ff    <= bad_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         line_ff[count_ff[hcw_pkg::LINE_IDX_W-1:0]] <= cmd.ch;
      end
   end

   always_comb begin
      stat.empty = (count_ff == '0);
      stat.full  = (count_ff >= hcw_pkg::COUNT_W'(hcw_pkg::LINE_CAP));
      stat.done  = done_ff;
      stat.bad   = bad_ff;
      stat.addr  = addr_ff;
      stat.val   = val_ff;
   end

endmodule

`default_nettype wire

// ----- rtl/hex_command_line_byte_writer.sv -----
// ----------------------------------------------------------------------------
// hex_command_line_byte_writer
// Echo: a stored character is echoed from S_ECHO through the output
// register; an erase gives backspace, space, backspace, and an end of line
// gives newline and return, then the outcome once the line unit has parsed
// the held characters.
// Input: one character at a time; the next one is taken only back in S_IDLE,
// after the last result of the current one has been loaded.
// Reset: the store is swept to 0xFF, one byte per cycle, and no character is
// taken before the sweep is over; the line starts empty.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_command_line_byte_writer (
   input  wire          clock,
   input  wire          reset,
   hcw_req_if.sink      req_chan,
   hcw_rsp_if.source    rsp_chan
);

   // Sequencer state. The block takes a character only in S_IDLE; every
   // result passes through the output register below, so a new character
   // can be taken while the last result of the previous one still waits.
   hcw_pkg::state_type     state_ff;
   hcw_pkg::state_type     state_in;
   hcw_pkg::action_type    action_ff;
   hcw_pkg::action_type    action_in;
   logic [1:0]             step_ff;
   logic [1:0]             step_in;
   logic [7:0]             echo_char_ff;
   logic [7:0]             echo_char_in;

   // Output register.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_kind_ff;
   logic [7:0]             rsp_tx_ff;
   logic [1:0]             rsp_status_ff;
   logic [15:0]            rsp_addr_ff;
   logic [7:0]             rsp_val_ff;
   logic [7:0]             rsp_old_ff;
   logic                   rsp_last_ff;
   logic                   load;
   logic                   ld_kind;
   logic [7:0]             ld_tx;
   hcw_pkg::status_type    ld_status;
   logic [15:0]            ld_addr;
   logic [7:0]             ld_val;
   logic [7:0]             ld_old;
   logic                   ld_last;

   hcw_pkg::line_cmd_type  line_cmd;
   hcw_pkg::line_stat_type line_stat;
   hcw_pkg::store_req_type store_req;
   logic [7:0]             store_rd_data;
   logic                   store_busy;

   logic                   out_free;
   logic                   accept;
   logic [7:0]             c;
   logic                   is_erase;
   logic                   is_line;
   logic                   in_range;

   hcw_line_unit u_line (
      .clock (clock),
      .reset (reset),
      .cmd   (line_cmd),
      .stat  (line_stat)
   );

   hcw_byte_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (store_req),
      .rd_data (store_rd_data),
      .busy    (store_busy)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == hcw_pkg::S_IDLE);
   assign accept   = req_chan.valid && req_chan.ready;
   assign c        = req_chan.rx_char;
   assign is_erase = (c == hcw_pkg::CH_DEL) || (c == hcw_pkg::CH_BS);
   assign is_line  = hcw_pkg::is_line_char(c);
   assign in_range = ({1'b0, line_stat.addr} < 17'(hcw_pkg::STORE_BYTES));

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      step_in      = step_ff;
      echo_char_in = echo_char_ff;

      line_cmd.push  = 1'b0;
      line_cmd.pop   = 1'b0;
      line_cmd.start = 1'b0;
      line_cmd.ch    = c;

      store_req.rd_en = 1'b0;
      store_req.wr_en = 1'b0;
      store_req.addr  = line_stat.addr[hcw_pkg::STORE_AW-1:0];
      store_req.data  = line_stat.val;

      load      = 1'b0;
      ld_kind   = hcw_pkg::KIND_ECHO;
      ld_tx     = 8'h00;
      ld_status = hcw_pkg::STATUS_WRITTEN;
      ld_addr   = 16'h0000;
      ld_val    = 8'h00;
      ld_old    = 8'h00;
      ld_last   = 1'b0;

      case (state_ff)
         hcw_pkg::S_CLEAR: begin
            if (!store_busy) begin
               state_in = hcw_pkg::S_IDLE;
            end
         end
         hcw_pkg::S_IDLE: begin
            // Classify the character; anything unknown is dropped silently.
            if (accept) begin
               step_in = 2'd0;
               if (is_erase) begin
                  if (!line_stat.empty) begin
                     line_cmd.pop = 1'b1;
                     action_in    = hcw_pkg::ACT_ERASE;
                     state_in     = hcw_pkg::S_ECHO;
                  end
               end else if (c == hcw_pkg::CH_CR || (is_line && line_stat.full)) begin
                  action_in = hcw_pkg::ACT_END;
                  state_in  = hcw_pkg::S_ECHO;
               end else if (is_line) begin
                  line_cmd.push = 1'b1;
                  echo_char_in  = c;
                  action_in     = hcw_pkg::ACT_STORE;
                  state_in      = hcw_pkg::S_ECHO;
               end
            end
         end
         hcw_pkg::S_ECHO: begin
            if (out_free) begin
               load    = 1'b1;
               step_in = step_ff + 2'd1;
               case (action_ff)
                  hcw_pkg::ACT_ERASE: begin
                     // Backspace, space, backspace rubs out the last character.
                     ld_tx = (step_ff == 2'd1) ? hcw_pkg::CH_SP : hcw_pkg::CH_BS;
                     if (step_ff == 2'd2) begin
                        ld_last  = 1'b1;
                        state_in = hcw_pkg::S_IDLE;
                     end
                  end
                  hcw_pkg::ACT_END: begin
                     ld_tx = (step_ff == 2'd0) ? hcw_pkg::CH_LF : hcw_pkg::CH_CR;
                     if (step_ff == 2'd1) begin
                        line_cmd.start = 1'b1;
                        state_in       = hcw_pkg::S_PARSE;
                     end
                  end
                  default: begin
                     ld_tx    = echo_char_ff;
                     ld_last  = 1'b1;
                     state_in = hcw_pkg::S_IDLE;
                  end
               endcase
            end
         end
         hcw_pkg::S_PARSE: begin
            // The parsed address is registered when done rises, so the
            // store read can start in the same cycle.
            if (line_stat.done) begin
               store_req.rd_en = 1'b1;
               state_in        = hcw_pkg::S_DECIDE;
            end
         end
         hcw_pkg::S_DECIDE: begin
            if (out_free) begin
               load    = 1'b1;
               ld_kind = hcw_pkg::KIND_OUTCOME;
               ld_last = 1'b1;
               if (line_stat.bad) begin
                  ld_status = hcw_pkg::STATUS_BAD;
               end else begin
                  ld_addr = line_stat.addr;
                  ld_val  = line_stat.val;
                  if (!in_range) begin
                     ld_status = hcw_pkg::STATUS_RANGE;
                  end else begin
                     ld_old = store_rd_data;
                     if (store_rd_data != line_stat.val) begin
                        ld_status       = hcw_pkg::STATUS_WRITTEN;
                        store_req.wr_en = 1'b1;
                     end else begin
                        ld_status = hcw_pkg::STATUS_SAME;
                     end
                  end
               end
               state_in = hcw_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = hcw_pkg::S_IDLE;
         end
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hcw_pkg::S_CLEAR;
         action_ff    <= hcw_pkg::ACT_STORE;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         action_ff    <= action_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      echo_char_ff <= echo_char_in;
      if (load) begin
         rsp_kind_ff   <= ld_kind;
         rsp_tx_ff     <= ld_tx;
         rsp_status_ff <= ld_status;
         rsp_addr_ff   <= ld_addr;
         rsp_val_ff    <= ld_val;
         rsp_old_ff    <= ld_old;
         rsp_last_ff   <= ld_last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_kind_ff;
   assign rsp_chan.tx_char    = rsp_tx_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.address    = rsp_addr_ff;
   assign rsp_chan.data_value = rsp_val_ff;
   assign rsp_chan.old_value  = rsp_old_ff;
   assign rsp_chan.last       = rsp_last_ff;

   // No character is taken while the store is still being swept.
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> !req_chan.ready)
      else $error("character taken during store sweep");

   // A command outcome always closes the results of its character.
   a_outcome_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind == hcw_pkg::KIND_OUTCOME) |-> rsp_chan.last)
      else $error("command outcome not marked last");

   // A badly formed line reports no address, value or old byte.
   a_bad_is_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind == hcw_pkg::KIND_OUTCOME &&
       rsp_chan.status == hcw_pkg::STATUS_BAD) |->
      (rsp_chan.address == 16'h0000 && rsp_chan.data_value == 8'h00 &&
       rsp_chan.old_value == 8'h00))
      else $error("bad format outcome carries fields");

   // The store is written only when the outcome is loaded as written.
   a_write_matches_status: assert property (@(posedge clock) disable iff (reset)
      store_req.wr_en |=> (rsp_chan.valid && rsp_chan.status == hcw_pkg::STATUS_WRITTEN &&
                           rsp_chan.old_value != rsp_chan.data_value))
      else $error("store write without a written outcome");

   // The parser finishes only while the sequencer waits for it.
   a_done_in_parse: assert property (@(posedge clock) disable iff (reset)
      line_stat.done |-> (state_ff == hcw_pkg::S_PARSE))
      else $error("parse finished outside the parse state");

endmodule

`default_nettype wire

// ----- bench/hcw_reply_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcw_reply_checker
// Watches the character and reply channels of the hex command line byte
// writer, keeps its own copy of the line buffer and byte store, and compares
// every reply with the oldest one still due.
// ----------------------------------------------------------------------------

module hcw_reply_checker
   import hcw_pkg::*;
(
   input  logic clock,
   input  logic reset,
   hcw_req_if   req_chan,
   hcw_rsp_if   rsp_chan,
   output int   failures,
   output int   pending
);

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx_char;
      status_type  status;
      logic [15:0] address;
      logic [7:0]  data_value;
      logic [7:0]  old_value;
      logic        last;
   } reply_type;

   logic [7:0] line_buf [LINE_CAP];
   int         line_len;
   logic [7:0] store_img [STORE_BYTES];
   reply_type  due_replies [$];

   initial begin
      line_len = 0;
      failures = 0;
      pending  = 0;
      for (int i = 0; i < STORE_BYTES; i++) begin
         store_img[i] = CH_FILL;
      end
   end

   // Digit value of a hex character, or -1 when it is not one.
   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic bit storable(input logic [7:0] c);
      return (hex_nibble(c) >= 0) || (c == CH_SP);
   endfunction

   function automatic void push_echo(input logic [7:0] c, input logic is_last);
      due_replies.push_back('{kind: KIND_ECHO, tx_char: c, status: STATUS_WRITTEN,
                              address: 16'd0, data_value: 8'd0, old_value: 8'd0,
                              last: is_last});
   endfunction

   // Parses the held line as address, spaces, value, and applies the write.
   function automatic reply_type run_line();
      int          pos;
      int          ndig;
      int          nib;
      logic [15:0] addr;
      logic [7:0]  val;
      bit          bad;
      reply_type   r;
      pos  = 0;
      ndig = 0;
      addr = '0;
      val  = '0;
      bad  = 1'b0;
      while (!bad && pos < line_len && line_buf[pos] != CH_SP) begin
         nib = hex_nibble(line_buf[pos]);
         if (ndig >= 4 || nib < 0) begin
            bad = 1'b1;
         end else begin
            addr = {addr[11:0], nib[3:0]};
            ndig++;
            pos++;
         end
      end
      if (ndig == 0) bad = 1'b1;
      while (!bad && pos < line_len && line_buf[pos] == CH_SP) pos++;
      ndig = 0;
      while (!bad && pos < line_len) begin
         nib = hex_nibble(line_buf[pos]);
         if (ndig >= 2 || nib < 0) begin
            bad = 1'b1;
         end else begin
            val = {val[3:0], nib[3:0]};
            ndig++;
            pos++;
         end
      end
      if (ndig == 0) bad = 1'b1;

      r = '{kind: KIND_OUTCOME, tx_char: 8'd0, status: STATUS_BAD, address: 16'd0,
            data_value: 8'd0, old_value: 8'd0, last: 1'b1};
      if (!bad) begin
         r.address    = addr;
         r.data_value = val;
         if (addr >= STORE_BYTES) begin
            r.status = STATUS_RANGE;
         end else begin
            r.old_value = store_img[addr[STORE_AW-1:0]];
            if (store_img[addr[STORE_AW-1:0]] != val) begin
               r.status = STATUS_WRITTEN;
               store_img[addr[STORE_AW-1:0]] = val;
            end else begin
               r.status = STATUS_SAME;
            end
         end
      end
      return r;
   endfunction

   // Works out the replies that one received character causes.
   function automatic void apply_rx_char(input logic [7:0] c);
      if (c == CH_DEL || c == CH_BS) begin
         if (line_len > 0) begin
            line_len--;
            push_echo(CH_BS, 1'b0);
            push_echo(CH_SP, 1'b0);
            push_echo(CH_BS, 1'b1);
         end
      end else if (c == CH_CR || (storable(c) && line_len >= LINE_CAP)) begin
         push_echo(CH_LF, 1'b0);
         push_echo(CH_CR, 1'b0);
         due_replies.push_back(run_line());
         line_len = 0;
      end else if (storable(c)) begin
         line_buf[line_len] = c;
         line_len++;
         push_echo(c, 1'b1);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      failures++;
      $display("%0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("reply field %s: got %0h, expected %0h",
                                   name, got, want));
      end
   endtask

   always @(posedge clock) begin : watch
      reply_type want;
      if (!reset) begin
         // A reply can never be caused by a character taken at the same edge,
         // so the comparison goes first.
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (due_replies.size() == 0) begin
               report_mismatch($sformatf("reply with nothing due: kind %0d char %0h",
                                         rsp_chan.kind, rsp_chan.tx_char));
            end else begin
               want = due_replies.pop_front();
               check_field("kind", 16'(rsp_chan.kind), 16'(want.kind));
               check_field("tx_char", 16'(rsp_chan.tx_char), 16'(want.tx_char));
               check_field("status", 16'(rsp_chan.status), 16'(want.status));
               check_field("address", rsp_chan.address, want.address);
               check_field("data_value", 16'(rsp_chan.data_value),
                           16'(want.data_value));
               check_field("old_value", 16'(rsp_chan.old_value),
                           16'(want.old_value));
               check_field("last", 16'(rsp_chan.last), 16'(want.last));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            apply_rx_char(req_chan.rx_char);
         end
      end
      pending <= due_replies.size();
   end

endmodule

// ----- bench/tb_hex_command_line_byte_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_command_line_byte_writer
// Types command lines into the byte writer one character at a time, with
// random gaps and stalls on both channels, and gives the verdict from the
// failure count of the reply checker.
// ----------------------------------------------------------------------------

module tb_hex_command_line_byte_writer;
   import hcw_pkg::*;

   // Characters that take effect (not counting ignored bytes) before the
   // random part stops.
   localparam int ITEM_TARGET   = 400;
   // Length of the long receiver hold-off that fills the block up.
   localparam int HOLD_CYCLES   = 300;
   // Cycles without any transaction before the run is declared hung. The
   // limit covers the store sweep after reset and the receiver hold-off.
   localparam int QUIET_LIMIT   = 5000;
   // Cycles allowed after the last reply for anything unexpected to show up.
   localparam int SETTLE_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int failures;
   int pending;
   int sent_items = 0;

   // Set by the stimulus to start the long hold-off; the receiver clears it.
   bit hold_go = 1'b0;
   // While set, neither side inserts random idle cycles.
   bit calm = 1'b0;

   hcw_req_if req_chan ();
   hcw_rsp_if rsp_chan ();

   always #5 clock = ~clock;

   hex_command_line_byte_writer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hcw_reply_checker reply_check (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .failures (failures),
      .pending  (pending)
   );

   // True for every character that changes the line or ends it; everything
   // else is dropped by the block without a reply.
   function automatic bit takes_effect(input logic [7:0] c);
      return (c == CH_CR) || (c == CH_DEL) || (c == CH_BS) || (c == CH_SP) ||
             (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
             (c >= "A" && c <= "F");
   endfunction

   // Hex digit for a nibble, in a random letter case.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return "0" + n;
      return ($urandom_range(0, 1) ? "a" : "A") + (n - 4'd10);
   endfunction

   function automatic int hex_width(input logic [15:0] v);
      if (v < 16'h10) return 1;
      if (v < 16'h100) return 2;
      if (v < 16'h1000) return 3;
      return 4;
   endfunction

   function automatic logic [7:0] erase_char();
      return $urandom_range(0, 1) ? CH_DEL : CH_BS;
   endfunction

   // Any character that may sit in the line: a hex digit or a space.
   function automatic logic [7:0] line_char();
      if ($urandom_range(0, 16) == 0) return CH_SP;
      return hex_char(4'($urandom_range(0, 15)));
   endfunction

   // Offers one character and returns at the edge where it is taken. Valid
   // stays high into the next call, so back-to-back transactions have no gap
   // unless the random idle decides otherwise.
   task automatic send_char(input logic [7:0] c);
      while (!calm && $urandom_range(0, 99) < 8) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_char <= c;
      do @(posedge clock); while (!req_chan.ready);
      if (takes_effect(c)) sent_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_hex(input logic [15:0] v, input int ndig);
      for (int i = ndig - 1; i >= 0; i--) send_char(hex_char(v[i*4 +: 4]));
   endtask

   // Drops valid and waits until the checker has nothing left due.
   task automatic wait_for_replies();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // A correct command with random content. Most addresses come from a small
   // set so that repeated writes also hit the unchanged case. With fill_line
   // the gap is padded so the line is exactly full and the next digit or
   // space ends it instead of a return.
   task automatic send_command(input bit fill_line);
      logic [15:0] addr;
      logic [7:0]  val;
      int          sel;
      int          adig;
      int          vdig;
      int          gap;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         addr = 16'($urandom_range(0, 7));
      end else if (sel < 65) begin
         addr = 16'(STORE_BYTES - 1);
      end else if (sel < 85) begin
         addr = 16'($urandom_range(0, STORE_BYTES - 1));
      end else begin
         addr = 16'($urandom_range(0, 16'hFFFF));
      end
      case ($urandom_range(0, 5))
         0:       val = 8'h00;
         1:       val = CH_FILL;
         2:       val = 8'h5A;
         default: val = 8'($urandom_range(0, 255));
      endcase
      adig = $urandom_range(hex_width(addr), 4);
      vdig = $urandom_range(hex_width({8'h00, val}), 2);
      gap  = fill_line ? LINE_CAP - adig - vdig : $urandom_range(1, 3);

      send_hex(addr, adig);
      // A stray byte that the block must simply drop.
      if (!fill_line && $urandom_range(0, 9) == 0) begin
         send_char($urandom_range(0, 1) ? "g" : 8'h00);
      end
      repeat (gap) send_char(CH_SP);
      // A typo that is erased again before the value.
      if (!fill_line && $urandom_range(0, 7) == 0) begin
         send_char(line_char());
         send_char(erase_char());
      end
      send_hex({8'h00, val}, vdig);
      send_char(fill_line ? line_char() : CH_CR);
   endtask

   // Lines that must end in a bad format outcome, plus one that is filled
   // with random digits and spaces until it overflows.
   task automatic send_broken();
      case ($urandom_range(0, 6))
         0: begin
            // Address and a space but no value.
            send_hex(16'($urandom_range(0, 255)), 2);
            send_char(CH_SP);
            send_char(CH_CR);
         end
         1: begin
            // Value of three digits.
            send_hex(16'($urandom_range(0, 255)), 2);
            send_char(CH_SP);
            send_hex(16'($urandom_range(0, 4095)), 3);
            send_char(CH_CR);
         end
         2: begin
            // Space inside the value.
            send_hex(16'($urandom_range(0, 15)), 1);
            send_char(CH_SP);
            send_hex(16'($urandom_range(0, 15)), 1);
            send_char(CH_SP);
            send_hex(16'($urandom_range(0, 15)), 1);
            send_char(CH_CR);
         end
         3: begin
            // Address of five digits.
            send_hex(16'($urandom_range(0, 16'hFFFF)), 4);
            send_hex(16'($urandom_range(0, 15)), 1);
            send_char(CH_SP);
            send_hex(16'($urandom_range(0, 15)), 1);
            send_char(CH_CR);
         end
         4: begin
            // Leading space leaves the address empty.
            send_char(CH_SP);
            send_hex(16'($urandom_range(0, 255)), 2);
            send_char(CH_SP);
            send_hex(16'($urandom_range(0, 255)), 2);
            send_char(CH_CR);
         end
         5: begin
            // Random digits and spaces; the last one overflows the line.
            repeat (LINE_CAP + 1) send_char(line_char());
         end
         default: begin
            // Everything erased, then one erase more on the empty line.
            send_hex(16'($urandom_range(0, 255)), 2);
            repeat (3) send_char(erase_char());
            send_char(CH_CR);
         end
      endcase
   endtask

   // Random bytes over the whole range, closed by a return.
   task automatic send_noise();
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
      send_char(CH_CR);
   endtask

   // The receiver stalls at random, except during the calm stretch, and holds
   // ready low for a long run when the stimulus asks for it.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= calm || ($urandom_range(0, 99) >= 8);
         end
      end
   end

   // The run is declared hung after a long stretch with no transaction on
   // either channel.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      bit held;
      bit drained;
      int pick;
      held    = 1'b0;
      drained = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.rx_char = 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Erases on the empty line and unknown bytes give no
      // reply at all.
      send_char(CH_DEL);
      send_char(CH_BS);
      send_char(8'h00);
      send_char(8'hFF);
      send_char("g");
      // Lowest address; the store is still 0xFF after the sweep, so this
      // one leaves it unchanged.
      send_text("0 ff");
      send_char(CH_CR);
      // Highest address inside the store, with an erased digit in the value.
      send_text("3Ff 0");
      send_char(CH_BS);
      send_text("A");
      send_char(CH_CR);
      // Highest address the line can hold is out of range.
      send_text("ffff 1");
      send_char(CH_CR);
      // An empty line is a bad format.
      send_char(CH_CR);
      // Value of three digits.
      send_text("12 345");
      send_char(CH_CR);

      // Random part: mostly well-formed commands, some overflowing lines,
      // some broken lines and some raw noise.
      while (sent_items < ITEM_TARGET) begin
         if (!held && sent_items >= 100) begin
            // The receiver stops for a long time while characters keep
            // coming, so the block backs up and stalls its input.
            held    = 1'b1;
            hold_go = 1'b1;
         end
         if (!drained && sent_items >= 300) begin
            drained = 1'b1;
            wait_for_replies();
         end
         calm = (sent_items >= 180 && sent_items < 260);
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            send_command(1'b0);
         end else if (pick < 75) begin
            send_command(1'b1);
         end else if (pick < 88) begin
            send_broken();
         end else begin
            send_noise();
         end
      end

      wait_for_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/hcw_pkg.sv
rtl/hcw_ifs.sv
rtl/hcw_byte_store.sv
rtl/hcw_line_unit.sv
rtl/hex_command_line_byte_writer.sv
bench/hcw_reply_checker.sv
bench/tb_hex_command_line_byte_writer.sv
